// ===== rtl/torus_surface_evaluate_assert.svh =====
// Assertion macros for the torus surface evaluator checker.
// Used by tse_chk only; no other dependencies.
`ifndef TORUS_SURFACE_EVALUATE_ASSERT_SVH
`define TORUS_SURFACE_EVALUATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSE_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("torus_surface_evaluate: assertion failed");

// next-cycle implication, disabled in reset
`define TSE_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("torus_surface_evaluate: assertion failed");

// holds in the cycle after reset is seen
`define TSE_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("torus_surface_evaluate: reset assertion failed");

`endif

// ===== rtl/tse_pkg.sv =====
// Shared types, constants and helper functions of the torus surface evaluator.
// No dependencies.
`default_nettype none
package tse_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // pi/2 in Q30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    // reciprocal scale for the constant divides in the series
    localparam int DIV_SHIFT = 41;
    // trig pipeline: angle scale, 6 terms of 3 stages, final sum, rounding
    localparam int TRIG_LAT  = 21;
    // items between accept and back end pop
    localparam int QDEPTH    = 8;

    localparam logic [31:0] CENTER_RST = 32'd0;
    localparam logic [53:0] XAXIS_RST  = 54'd65536;
    localparam logic [53:0] YAXIS_RST  = 54'd65536 << 18;
    localparam logic [53:0] ZAXIS_RST  = 54'd65536 << 36;
    localparam logic [31:0] MAJOR_RST  = 32'd131072;
    localparam logic [31:0] MINOR_RST  = 32'd65536;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_X_AXIS   = 3'd3,
        CFG_Y_AXIS   = 3'd4,
        CFG_Z_AXIS   = 3'd5,
        CFG_RADII    = 3'd6,
        CFG_LEMON    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_POS = 3'd0,
        KIND_DU  = 3'd1,
        KIND_DV  = 3'd2,
        KIND_NRM = 3'd3,
        KIND_DUU = 3'd4,
        KIND_DUV = 3'd5,
        KIND_DVV = 3'd6
    } t_kind;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [2:0][53:0] axis;
        logic [31:0]      major;
        logic [31:0]      minor;
        logic             lemon;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        logic [6:0]       mask;
        logic [2:0][19:0] ax;
        logic [2:0][19:0] bx;
        logic [33:0]      rc;
        logic [33:0]      rs;
        logic [35:0]      m;
        logic [17:0]      cv;
        logic [17:0]      sv;
    } t_job;

    // divisor n(n+1) of sine term j (n = 2j+2)
    function automatic int sin_div(input int j);
        int n;
        n = 2 * j + 2;
        return n * (n + 1);
    endfunction

    // divisor n(n+1) of cosine term j (n = 2j+1)
    function automatic int cos_div(input int j);
        int n;
        n = 2 * j + 1;
        return n * (n + 1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tse_in_if.sv =====
// Input channel of the torus surface evaluator: (u,v) angles and output mask.
// No dependencies.
`default_nettype none
interface tse_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] u_angle;
    logic [15:0] v_angle;
    logic [6:0]  output_mask;

    modport source (output valid, output u_angle, output v_angle, output output_mask,
                    input ready);
    modport sink   (input valid, input u_angle, input v_angle, input output_mask,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/tse_out_if.sv =====
// Output channel of the torus surface evaluator: one 3D vector per transaction.
// No dependencies.
`default_nettype none
interface tse_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         vector_kind;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               last_of_run;

    modport source (output valid, output vector_kind, output vec_x, output vec_y,
                    output vec_z, output last_of_run, input ready);
    modport sink   (input valid, input vector_kind, input vec_x, input vec_y,
                    input vec_z, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/torus_surface_evaluate.sv =====
// Torus surface evaluator: position, derivatives and normal at (u,v).
// Pipeline: input register, trig pipeline, 3 frame stages, queue write, 4-stage
// vector pipeline. Throughput: one vector per cycle while the output is not
// stalled; an item yields one vector per selected mask bit, and an empty mask
// yields none. At most 8 items in flight; each credit returns when the back end
// pops the item.
// Synchronous active-low reset clears control state and restores config defaults.
`default_nettype none
module torus_surface_evaluate #(
    parameter int ANGLE_BITS      = tse_pkg::ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = tse_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tse_in_if.sink           i_in,
    tse_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    localparam int QD = tse_pkg::QDEPTH;
    localparam int CW = $clog2(QD + 1);

    tse_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center <= {3{tse_pkg::CENTER_RST}};
            r_cfg.axis   <= {tse_pkg::ZAXIS_RST, tse_pkg::YAXIS_RST, tse_pkg::XAXIS_RST};
            r_cfg.major  <= tse_pkg::MAJOR_RST;
            r_cfg.minor  <= tse_pkg::MINOR_RST;
            r_cfg.lemon  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (tse_pkg::t_cfg_idx'(i_cfg_idx))
                tse_pkg::CFG_CENTER_X: r_cfg.center[0] <= i_cfg_data[31:0];
                tse_pkg::CFG_CENTER_Y: r_cfg.center[1] <= i_cfg_data[31:0];
                tse_pkg::CFG_CENTER_Z: r_cfg.center[2] <= i_cfg_data[31:0];
                tse_pkg::CFG_X_AXIS:   r_cfg.axis[0]   <= i_cfg_data[53:0];
                tse_pkg::CFG_Y_AXIS:   r_cfg.axis[1]   <= i_cfg_data[53:0];
                tse_pkg::CFG_Z_AXIS:   r_cfg.axis[2]   <= i_cfg_data[53:0];
                tse_pkg::CFG_RADII: begin
                    r_cfg.major <= i_cfg_data[63:32];
                    r_cfg.minor <= i_cfg_data[31:0];
                end
                tse_pkg::CFG_LEMON:    r_cfg.lemon     <= i_cfg_data[0];
            endcase
        end
    end

    // items accepted but not yet taken by the back end; bounds the queue
    logic [CW-1:0] r_cnt;
    logic          w_acc, w_pop, w_fv, w_nempty;
    tse_pkg::t_job w_fjob;
    logic [$bits(tse_pkg::t_job)-1:0] w_q;

    assign i_in.ready = (r_cnt < CW'(QD));
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(w_acc) - CW'(w_pop);
        end
    end

    tse_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_u     (i_in.u_angle),
        .i_v     (i_in.v_angle),
        .i_mask  (i_in.output_mask),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_job   (w_fjob)
    );

    tse_fifo #(.WIDTH($bits(tse_pkg::t_job)), .DEPTH(QD)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fv),
        .i_data   (w_fjob),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_data   (w_q)
    );

    tse_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nempty (w_nempty),
        .i_job    (tse_pkg::t_job'(w_q)),
        .i_cfg    (r_cfg),
        .o_pop    (w_pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_kind   (o_out.vector_kind),
        .o_x      (o_out.vec_x),
        .o_y      (o_out.vec_y),
        .o_z      (o_out.vec_z),
        .o_last   (o_out.last_of_run)
    );
endmodule
`default_nettype wire

// ===== rtl/tse_trig.sv =====
// Pipelined sine/cosine of a binary angle, Taylor series in Q30, Q16 result.
// Depends on tse_pkg.
`default_nettype none
module tse_trig #(
    parameter int ANGLE_BITS = tse_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [17:0]         o_sin,
    output logic signed [17:0]         o_cos
);
    localparam int FB = ANGLE_BITS - 2;

    logic [30:0]        e_t  [0:6];
    logic [1:0]         e_q  [0:6];
    logic [32:0]        e_ts [0:6];
    logic [32:0]        e_tc [0:6];
    logic signed [34:0] e_ss [0:6];
    logic signed [34:0] e_sc [0:6];

    logic [FB+30:0] w_tp;
    logic [30:0]    r_t;
    logic [1:0]     r_q;

    assign w_tp = (FB + 31)'(i_angle[FB-1:0]) * (FB + 31)'(tse_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        r_t <= w_tp[FB+30:FB];
        r_q <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end

    assign e_t[0]  = r_t;
    assign e_q[0]  = r_q;
    assign e_ts[0] = 33'(r_t);
    assign e_tc[0] = 33'(tse_pkg::ONE_Q30);
    assign e_ss[0] = 35'(r_t);
    assign e_sc[0] = 35'(tse_pkg::ONE_Q30);

    for (genvar j = 0; j < 6; j++) begin : g_term
        localparam int DS = tse_pkg::sin_div(j);
        localparam int DC = tse_pkg::cos_div(j);
        localparam logic [63:0] MS =
            ((64'd1 << tse_pkg::DIV_SHIFT) + 64'(DS) - 64'd1) / 64'(DS);
        localparam logic [63:0] MC =
            ((64'd1 << tse_pkg::DIV_SHIFT) + 64'(DC) - 64'd1) / 64'(DC);

        logic [63:0]        w_as, w_ac, w_bs, w_bc;
        logic [73:0]        w_cs, w_cc;
        logic signed [34:0] w_ss, w_sc;
        logic [30:0]        r_at, r_bt, r_ct;
        logic [1:0]         r_aq, r_bq, r_cq;
        logic [32:0]        r_axs, r_axc, r_bxs, r_bxc, r_cts, r_ctc;
        logic signed [34:0] r_ass, r_asc, r_bss, r_bsc, r_css, r_csc;

        // previous term joins the sums here; terms alternate minus, plus
        if (j == 0) begin : g_first
            assign w_ss = e_ss[j];
            assign w_sc = e_sc[j];
        end else if (j % 2 == 1) begin : g_sub
            assign w_ss = e_ss[j] - $signed({2'b00, e_ts[j]});
            assign w_sc = e_sc[j] - $signed({2'b00, e_tc[j]});
        end else begin : g_add
            assign w_ss = e_ss[j] + $signed({2'b00, e_ts[j]});
            assign w_sc = e_sc[j] + $signed({2'b00, e_tc[j]});
        end

        assign w_as = 64'(e_ts[j]) * 64'(e_t[j]);
        assign w_ac = 64'(e_tc[j]) * 64'(e_t[j]);
        assign w_bs = 64'(r_axs) * 64'(r_at);
        assign w_bc = 64'(r_axc) * 64'(r_at);
        assign w_cs = 74'(r_bxs) * 74'(MS);
        assign w_cc = 74'(r_bxc) * 74'(MC);

        always_ff @(posedge i_clk) begin
            r_at  <= e_t[j];
            r_aq  <= e_q[j];
            r_axs <= w_as[62:30];
            r_axc <= w_ac[62:30];
            r_ass <= w_ss;
            r_asc <= w_sc;

            r_bt  <= r_at;
            r_bq  <= r_aq;
            r_bxs <= w_bs[62:30];
            r_bxc <= w_bc[62:30];
            r_bss <= r_ass;
            r_bsc <= r_asc;

            r_ct  <= r_bt;
            r_cq  <= r_bq;
            r_cts <= w_cs[73:41];
            r_ctc <= w_cc[73:41];
            r_css <= r_bss;
            r_csc <= r_bsc;
        end

        assign e_t[j+1]  = r_ct;
        assign e_q[j+1]  = r_cq;
        assign e_ts[j+1] = r_cts;
        assign e_tc[j+1] = r_ctc;
        assign e_ss[j+1] = r_css;
        assign e_sc[j+1] = r_csc;
    end

    logic signed [34:0] r_fs, r_fc;
    logic [1:0]         r_fq;
    logic [16:0]        w_qs, w_qc;
    logic signed [17:0] w_ps, w_pc;

    function automatic logic [16:0] to_q16(input logic signed [34:0] s);
        logic [30:0] cl;
        logic [31:0] sum;
        if (s < 0) begin
            cl = 31'd0;
        end else if (s > 35'(tse_pkg::ONE_Q30)) begin
            cl = tse_pkg::ONE_Q30;
        end else begin
            cl = s[30:0];
        end
        sum = 32'(cl) + 32'd8192;
        return sum[30:14];
    endfunction

    assign w_qs = to_q16(r_fs);
    assign w_qc = to_q16(r_fc);
    assign w_ps = $signed({1'b0, w_qs});
    assign w_pc = $signed({1'b0, w_qc});

    always_ff @(posedge i_clk) begin
        r_fs <= e_ss[6] + $signed({2'b00, e_ts[6]});
        r_fc <= e_sc[6] + $signed({2'b00, e_tc[6]});
        r_fq <= e_q[6];
        unique case (r_fq)
            2'd0: begin
                o_sin <= w_ps;
                o_cos <= w_pc;
            end
            2'd1: begin
                o_sin <= w_pc;
                o_cos <= -w_ps;
            end
            2'd2: begin
                o_sin <= -w_ps;
                o_cos <= -w_pc;
            end
            default: begin
                o_sin <= -w_pc;
                o_cos <= w_ps;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/tse_front.sv =====
// Front end: takes (u,v,mask), runs both trig pipelines and forms the frame
// terms A, B, r cos v, r sin v and R + r cos v. Depends on tse_pkg, tse_trig.
`default_nettype none
module tse_front #(
    parameter int ANGLE_BITS = tse_pkg::ANGLE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [15:0]  i_u,
    input  wire logic [15:0]  i_v,
    input  wire logic [6:0]   i_mask,
    input  wire tse_pkg::t_cfg i_cfg,
    output logic              o_valid,
    output tse_pkg::t_job     o_job
);
    localparam int LAT = tse_pkg::TRIG_LAT;

    logic [ANGLE_BITS+15:0] w_uext, w_vext;
    logic [ANGLE_BITS-1:0]  w_u, r_u, r_v;
    logic                   r_v0;
    logic [6:0]             r_m0;

    assign w_uext = {{ANGLE_BITS{1'b0}}, i_u};
    assign w_vext = {{ANGLE_BITS{1'b0}}, i_v};
    // lemon kind: half turn on u
    assign w_u = w_uext[ANGLE_BITS-1:0] +
                 (i_cfg.lemon ? {1'b1, {(ANGLE_BITS-1){1'b0}}} : '0);

    always_ff @(posedge i_clk) begin
        r_u  <= w_u;
        r_v  <= w_vext[ANGLE_BITS-1:0];
        r_m0 <= i_mask;
    end

    logic signed [17:0] w_su, w_cu, w_sv, w_cv;

    tse_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_u (
        .i_clk(i_clk), .i_angle(r_u), .o_sin(w_su), .o_cos(w_cu)
    );
    tse_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_v (
        .i_clk(i_clk), .i_angle(r_v), .o_sin(w_sv), .o_cos(w_cv)
    );

    logic [LAT-1:0] r_vdl;
    logic [6:0]     r_mdl [0:LAT-1];

    always_ff @(posedge i_clk) begin
        r_mdl[0] <= r_m0;
        for (int k = 1; k < LAT; k++) begin
            r_mdl[k] <= r_mdl[k-1];
        end
    end

    // stage 1: products
    logic signed [35:0] r_p1 [0:2];
    logic signed [35:0] r_p2 [0:2];
    logic signed [35:0] r_p3 [0:2];
    logic signed [35:0] r_p4 [0:2];
    logic signed [50:0] r_pc, r_ps;
    logic signed [17:0] r_cv1, r_sv1, r_cv2, r_sv2;
    logic [6:0]         r_m1, r_m2;
    logic               r_v1, r_v2, r_v3;
    // stage 2: rounded terms
    logic signed [19:0] r_ax2 [0:2];
    logic signed [19:0] r_bx2 [0:2];
    logic signed [33:0] r_rc2, r_rs2;
    // stage 3
    tse_pkg::t_job      r_job;

    logic signed [33:0] w_minor;
    assign w_minor = $signed({2'b00, i_cfg.minor});

    logic signed [36:0] w_sa [0:2];
    logic signed [36:0] w_sb [0:2];
    logic signed [51:0] w_rc, w_rs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sa[i] = 37'(r_p1[i]) + 37'(r_p2[i]) + 37'sd32768;
            w_sb[i] = 37'(r_p3[i]) - 37'(r_p4[i]) + 37'sd32768;
        end
        w_rc = 52'(r_pc) + 52'sd32768;
        w_rs = 52'(r_ps) + 52'sd32768;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p1[i] <= $signed(i_cfg.axis[0][18*i +: 18]) * w_cu;
            r_p2[i] <= $signed(i_cfg.axis[1][18*i +: 18]) * w_su;
            r_p3[i] <= $signed(i_cfg.axis[1][18*i +: 18]) * w_cu;
            r_p4[i] <= $signed(i_cfg.axis[0][18*i +: 18]) * w_su;
            r_ax2[i] <= w_sa[i][35:16];
            r_bx2[i] <= w_sb[i][35:16];
            r_job.ax[i] <= r_ax2[i];
            r_job.bx[i] <= r_bx2[i];
        end
        r_pc  <= w_cv * w_minor;
        r_ps  <= w_sv * w_minor;
        r_cv1 <= w_cv;
        r_sv1 <= w_sv;
        r_m1  <= r_mdl[LAT-1];

        r_rc2 <= w_rc[49:16];
        r_rs2 <= w_rs[49:16];
        r_cv2 <= r_cv1;
        r_sv2 <= r_sv1;
        r_m2  <= r_m1;

        r_job.m    <= $signed({4'b0000, i_cfg.major}) + 36'(r_rc2);
        r_job.rc   <= r_rc2;
        r_job.rs   <= r_rs2;
        r_job.mask <= r_m2;
        r_job.cv   <= r_cv2;
        r_job.sv   <= r_sv2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vdl <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_v0  <= i_valid;
            r_vdl <= {r_vdl[LAT-2:0], r_v0};
            r_v1  <= r_vdl[LAT-1];
            r_v2  <= r_v1;
            r_v3  <= r_v2;
        end
    end

    assign o_job   = r_job;
    assign o_valid = r_v3;
endmodule
`default_nettype wire

// ===== rtl/tse_fifo.sv =====
// Short register queue between front and back end.
// No dependencies.
`default_nettype none
module tse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_nempty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];
endmodule
`default_nettype wire

// ===== rtl/tse_back.sv =====
// Back end: walks the head item's mask and computes one vector a cycle unless
// stalled, via a shared multiply/round/saturate pipeline. Depends on tse_pkg.
`default_nettype none
module tse_back #(
    parameter int COORD_FRAC_BITS = tse_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_nempty,
    input  wire tse_pkg::t_job i_job,
    input  wire tse_pkg::t_cfg i_cfg,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_kind,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z,
    output logic               o_last
);
    localparam int NRM_SH = 32 - COORD_FRAC_BITS;
    localparam logic signed [57:0] HALF_STD = 58'sd1 <<< 15;
    localparam logic signed [57:0] HALF_NRM = 58'sd1 <<< (NRM_SH - 1);

    logic       en;
    logic       r_started;
    logic [6:0] r_rem;
    logic [6:0] w_cur, w_after;
    logic [2:0] w_k;

    assign en = !o_valid || i_ready;
    assign w_cur = r_started ? r_rem : i_job.mask;

    always_comb begin
        w_k = 3'd0;
        for (int b = 6; b >= 0; b--) begin
            if (w_cur[b]) begin
                w_k = 3'(b);
            end
        end
        w_after = w_cur & ~(7'd1 << w_k);
    end

    logic w_issue;
    assign w_issue = en && i_nempty && (w_cur != 7'd0);
    // an empty mask leaves the queue without a result
    assign o_pop   = en && i_nempty && (w_after == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_rem     <= '0;
        end else if (en && i_nempty) begin
            r_started <= (w_after != 7'd0);
            r_rem     <= w_after;
        end
    end

    // stage 0: operand select
    tse_pkg::t_kind     r_k0, r_k1, r_k2;
    logic               r_v0, r_v1, r_v2;
    logic               r_l0, r_l1, r_l2;
    logic signed [20:0] r_a1 [0:2];
    logic signed [20:0] r_a2 [0:2];
    logic signed [35:0] r_b1, r_b2;
    logic signed [56:0] r_p1 [0:2];
    logic signed [56:0] r_p2 [0:2];
    logic signed [57:0] r_s [0:2];

    logic signed [20:0] w_ax [0:2];
    logic signed [20:0] w_bx [0:2];
    logic signed [20:0] w_zc [0:2];
    logic signed [20:0] w_a1 [0:2];
    logic signed [20:0] w_a2 [0:2];
    logic signed [35:0] w_b1, w_b2;
    tse_pkg::t_kind     w_kind;

    assign w_kind = tse_pkg::t_kind'(w_k);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ax[i] = 21'($signed(i_job.ax[i]));
            w_bx[i] = 21'($signed(i_job.bx[i]));
            w_zc[i] = 21'($signed(i_cfg.axis[2][18*i +: 18]));
        end
        w_b1 = 36'($signed(i_job.m));
        w_b2 = '0;
        for (int i = 0; i < 3; i++) begin
            w_a1[i] = w_ax[i];
            w_a2[i] = '0;
        end
        unique case (w_kind)
            tse_pkg::KIND_POS: begin
                w_b2 = 36'($signed(i_job.rs));
                for (int i = 0; i < 3; i++) w_a2[i] = w_zc[i];
            end
            tse_pkg::KIND_DU: begin
                for (int i = 0; i < 3; i++) w_a1[i] = w_bx[i];
            end
            tse_pkg::KIND_DV: begin
                w_b1 = 36'($signed(i_job.rc));
                w_b2 = 36'($signed(i_job.rs));
                for (int i = 0; i < 3; i++) begin
                    w_a1[i] = w_zc[i];
                    w_a2[i] = -w_ax[i];
                end
            end
            tse_pkg::KIND_NRM: begin
                w_b1 = 36'($signed(i_job.cv));
                w_b2 = 36'($signed(i_job.sv));
                for (int i = 0; i < 3; i++) w_a2[i] = w_zc[i];
            end
            tse_pkg::KIND_DUU: begin
                for (int i = 0; i < 3; i++) w_a1[i] = -w_ax[i];
            end
            tse_pkg::KIND_DUV: begin
                w_b1 = 36'($signed(i_job.rs));
                for (int i = 0; i < 3; i++) w_a1[i] = -w_bx[i];
            end
            tse_pkg::KIND_DVV: begin
                w_b1 = 36'($signed(i_job.rc));
                w_b2 = 36'($signed(i_job.rs));
                for (int i = 0; i < 3; i++) begin
                    w_a1[i] = -w_ax[i];
                    w_a2[i] = -w_zc[i];
                end
            end
            default: begin
                w_b1 = '0;
            end
        endcase
    end

    logic signed [57:0] w_sh [0:2];
    logic signed [58:0] w_fin [0:2];
    logic signed [31:0] w_sat [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i]  = (r_k2 == tse_pkg::KIND_NRM) ? (r_s[i] >>> NRM_SH) : (r_s[i] >>> 16);
            w_fin[i] = 59'(w_sh[i]) +
                       ((r_k2 == tse_pkg::KIND_POS) ? 59'($signed(i_cfg.center[i])) : 59'sd0);
            if (w_fin[i] > 59'sd2147483647) begin
                w_sat[i] = 32'sh7fffffff;
            end else if (w_fin[i] < -59'sd2147483648) begin
                w_sat[i] = 32'sh80000000;
            end else begin
                w_sat[i] = w_fin[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k0 <= w_kind;
            r_l0 <= (w_after == 7'd0);
            r_b1 <= w_b1;
            r_b2 <= w_b2;
            r_k1 <= r_k0;
            r_l1 <= r_l0;
            r_k2 <= r_k1;
            r_l2 <= r_l1;
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= w_a1[i];
                r_a2[i] <= w_a2[i];
                r_p1[i] <= r_a1[i] * r_b1;
                r_p2[i] <= r_a2[i] * r_b2;
                r_s[i]  <= 58'(r_p1[i]) + 58'(r_p2[i]) +
                           ((r_k1 == tse_pkg::KIND_NRM) ? HALF_NRM : HALF_STD);
            end
            o_kind <= r_k2;
            o_last <= r_l2;
            o_x    <= w_sat[0];
            o_y    <= w_sat[1];
            o_z    <= w_sat[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v0    <= w_issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tse_chk.sv =====
// Port-level checker for the torus surface evaluator, bound to the top level.
// Depends on torus_surface_evaluate_assert.svh.
`default_nettype none
`include "torus_surface_evaluate_assert.svh"
module tse_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [6:0]  i_in_mask,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_kind,
    input wire logic [31:0] i_out_x,
    input wire logic [31:0] i_out_y,
    input wire logic [31:0] i_out_z,
    input wire logic        i_out_last
);
    logic       w_in_acc, w_out_acc;
    logic [7:0] r_open;
    logic       r_in_run;
    logic [2:0] r_prev;

    assign w_in_acc  = i_in_valid && i_in_ready && (i_in_mask != 7'd0);
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_in_run <= 1'b0;
            r_prev   <= '0;
        end else begin
            r_open <= r_open + 8'(w_in_acc) - 8'(w_out_acc && i_out_last);
            if (w_out_acc) begin
                r_in_run <= !i_out_last;
                r_prev   <= i_out_kind;
            end
        end
    end

    `TSE_RST(a_rst_idle, i_clk, i_rst_n, !i_out_valid)
    `TSE_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_last))
    `TSE_IMP(a_kind_order, i_clk, i_rst_n, w_out_acc && r_in_run, i_out_kind > r_prev)
    `TSE_IMP(a_no_orphan, i_clk, i_rst_n, i_out_valid, r_open != 8'd0)
endmodule

bind torus_surface_evaluate tse_chk u_tse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mask   (i_in.output_mask),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.vector_kind),
    .i_out_x     (o_out.vec_x),
    .i_out_y     (o_out.vec_y),
    .i_out_z     (o_out.vec_z),
    .i_out_last  (o_out.last_of_run)
);
`default_nettype wire
